FILE: design/ldhd_pkg.sv
// Shared types, widths and constants for the luma DC inverse Hadamard block.
package ldhd_pkg;

   localparam int COEFF_WIDTH = 16;
   localparam int OUT_W       = 36;

   localparam int F1_W   = COEFF_WIDTH + 2;
   localparam int F2_W   = COEFF_WIDTH + 4;
   localparam int LS_W   = 13;
   localparam int PROD_W = F2_W + LS_W + 1;
   localparam int SAT_W  = (PROD_W + 5 > OUT_W + 1) ? PROD_W + 5 : OUT_W + 1;

   localparam int  N_COEFF  = 16;
   localparam int  N_SCALE  = 6;
   localparam int  CSR_IW   = 3;

   // qp / 6 as (qp * 43) >> 8, exact for every 6-bit qp
   localparam int  DIV6_MUL   = 43;
   localparam int  DIV6_SHIFT = 8;

   localparam logic [3:0] QDIV_SHL_MIN = 4'd6;
   localparam logic [3:0] QDIV_RND_TOP = 4'd5;
   localparam logic [3:0] LAST_IDX     = 4'd15;

   localparam longint OUT_MAX = 64'sd34359738367;
   localparam longint OUT_MIN = -64'sd34359738368;

   // bit (row * 4 + col) set where the 4x4 Hadamard matrix holds -1
   localparam logic [N_COEFF-1:0] HADA_NEG = 16'hA6C0;

   localparam logic [CSR_IW-1:0] CSR_LEVEL_SCALE_M0 = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_LEVEL_SCALE_M1 = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_LEVEL_SCALE_M2 = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_LEVEL_SCALE_M3 = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_LEVEL_SCALE_M4 = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_LEVEL_SCALE_M5 = 3'd5;

   typedef logic [LS_W-1:0] level_scale_type;
   typedef level_scale_type [N_SCALE-1:0] scale_set_type;

   localparam scale_set_type SCALE_RESET = {13'd288, 13'd256, 13'd224,
                                            13'd208, 13'd176, 13'd160};

   typedef logic [COEFF_WIDTH-1:0] coeff_type;
   typedef coeff_type [N_COEFF-1:0] coeff_block_type;

   typedef struct packed {
      logic signed [COEFF_WIDTH-1:0] coeff_in;
      logic [5:0]                    quant_param;
      logic                          block_end;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] dc_value;
      logic                    run_last;
   } rsp_word_type;

   typedef struct packed {
      logic [3:0] qdiv;
      logic [2:0] qmod;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } job_push_type;

endpackage

FILE: design/ldhd_front.sv
// Front end: takes coefficient words, fills the store, queues a job per block end.
module ldhd_front import ldhd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_word_type    req_word,
   input  logic            job_taken,
   output job_push_type    job_push,
   output coeff_block_type store
);

   coeff_block_type store_ff, store_in;
   logic [3:0]      fill_ff, fill_in;
   logic            pending_ff, pending_in;
   logic            accept;
   logic [11:0]     qp_mul;
   logic [3:0]      qdiv;
   logic [5:0]      qdiv6;

   assign accept = start && !pending_ff;
   assign busy   = pending_ff;
   assign store  = store_ff;

   // classify qp into shift and scale select
   always_comb begin
      qp_mul = 12'(req_word.quant_param) * 12'(DIV6_MUL);
      qdiv   = qp_mul[DIV6_SHIFT +: 4];
      qdiv6  = {2'b00, qdiv} * 6'd6;
      job_push.job.qdiv = qdiv;
      job_push.job.qmod = 3'(req_word.quant_param - qdiv6);
      job_push.push     = accept && req_word.block_end;
   end

   always_comb begin
      store_in   = store_ff;
      fill_in    = fill_ff;
      pending_in = pending_ff;
      if (job_taken) begin
         pending_in = 1'b0;
      end
      if (accept) begin
         store_in[fill_ff] = req_word.coeff_in;
         if (req_word.block_end) begin
            fill_in    = '0;
            pending_in = 1'b1;
         end else begin
            fill_in = fill_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      if (reset) begin
         fill_ff    <= '0;
         pending_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         pending_ff <= pending_in;
      end
   end

endmodule

FILE: design/ldhd_queue.sv
// Two-entry job queue between the front end and the transform back end.
module ldhd_queue import ldhd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  job_push_type job_push,
   input  logic         pop,
   output logic         q_valid,
   output job_type      q_job
);

   job_type    slot_ff [2];
   job_type    slot_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_valid = (count_ff != 2'd0);
   assign q_job   = slot_ff[rd_ptr_ff];
   assign do_push = job_push.push && (count_ff != 2'd2);
   assign do_pop  = pop && q_valid;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         slot_in[wr_ptr_ff] = job_push.job;
         wr_ptr_in          = ~wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/ldhd_back.sv
// Back end: two Hadamard passes, then a serial scale / shift / saturate pipeline.
module ldhd_back import ldhd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  job_type         q_job,
   output logic            pop,
   input  coeff_block_type store,
   input  scale_set_type   scale,
   output logic            rsp_strobe,
   output rsp_word_type    rsp_word
);

   typedef enum logic [1:0] {ST_IDLE, ST_ROWS, ST_EMIT} state_type;

   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(OUT_MAX);
   localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(OUT_MIN);

   state_type                state_ff, state_in;
   job_type                  job_ff, job_in;
   logic [3:0]               count_ff, count_in;
   logic signed [F1_W-1:0]   f1_ff [N_COEFF];
   logic signed [F1_W-1:0]   f1_in [N_COEFF];
   logic signed [F1_W-1:0]   col_sum [N_COEFF];
   logic signed [F2_W-1:0]   line_ff [N_COEFF];
   logic signed [F2_W-1:0]   line_in [N_COEFF];
   logic signed [F2_W-1:0]   row_sum [N_COEFF];
   logic signed [LS_W:0]     ls_s;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic                     mul_vld_in, mul_vld_ff;
   logic                     mul_last_in, mul_last_ff;
   logic [3:0]               mul_qdiv_ff;
   logic signed [SAT_W-1:0]  wide, rnd, shifted;
   rsp_word_type             rsp_in, rsp_ff;
   logic                     rsp_vld_ff;

   // first pass: column transform H * C
   always_comb begin
      logic signed [F1_W-1:0] acc;
      logic signed [F1_W-1:0] cx;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
               cx  = F1_W'($signed(store[k*4 + j]));
               acc = HADA_NEG[i*4 + k] ? acc - cx : acc + cx;
            end
            col_sum[i*4 + j] = acc;
         end
      end
   end

   // second pass: row transform F1 * H
   always_comb begin
      logic signed [F2_W-1:0] acc;
      logic signed [F2_W-1:0] fx;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
               fx  = F2_W'(f1_ff[i*4 + k]);
               acc = HADA_NEG[k*4 + j] ? acc - fx : acc + fx;
            end
            row_sum[i*4 + j] = acc;
         end
      end
   end

   assign ls_s = $signed({1'b0, scale[job_ff.qmod]});

   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      count_in    = count_ff;
      f1_in       = f1_ff;
      line_in     = line_ff;
      pop         = 1'b0;
      mul_vld_in  = 1'b0;
      mul_last_in = 1'b0;
      prod_in     = line_ff[0] * ls_s;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               job_in   = q_job;
               f1_in    = col_sum;
               state_in = ST_ROWS;
            end
         end
         ST_ROWS: begin
            line_in  = row_sum;
            count_in = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            mul_vld_in  = 1'b1;
            mul_last_in = (count_ff == LAST_IDX);
            for (int n = 0; n < N_COEFF - 1; n++) begin
               line_in[n] = line_ff[n + 1];
            end
            count_in = count_ff + 4'd1;
            if (count_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // scale stage output: shift by qp/6, round, clamp
   always_comb begin
      wide = SAT_W'(prod_ff);
      rnd  = '0;
      if (mul_qdiv_ff >= QDIV_SHL_MIN) begin
         shifted = wide <<< 3'(mul_qdiv_ff - QDIV_SHL_MIN);
      end else begin
         rnd     = SAT_W'(1) <<< 3'(QDIV_RND_TOP - mul_qdiv_ff);
         shifted = (wide + rnd) >>> 3'(QDIV_SHL_MIN - mul_qdiv_ff);
      end
      priority if (shifted > SAT_HI) begin
         rsp_in.dc_value = OUT_W'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         rsp_in.dc_value = OUT_W'(SAT_LO);
      end else begin
         rsp_in.dc_value = shifted[OUT_W-1:0];
      end
      rsp_in.run_last = mul_last_ff;
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      f1_ff       <= f1_in;
      line_ff     <= line_in;
      prod_ff     <= prod_in;
      mul_last_ff <= mul_last_in;
      mul_qdiv_ff <= job_ff.qdiv;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         mul_vld_ff <= mul_vld_in;
         rsp_vld_ff <= mul_vld_ff;
      end
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_word   = rsp_ff;

endmodule

FILE: design/luma_dc_hadamard_dequant_top.sv
// Top level of the Intra 16x16 luma DC inverse Hadamard and dequantization block.
//   Input words (coefficient, qp, block end) are taken at each rising edge where
//   start is high and busy is low. Send the sixteen DC coefficients of a
//   macroblock in raster order; mark the sixteenth with block_end and put the
//   block's qp on that same word.
//   After a block-end word, busy holds high until the back end snapshots the
//   coefficient store: one cycle when the back end is idle, longer while it still
//   emits the previous block. The next block's words may follow once busy drops.
//   Results: with the back end idle, the block-end word passes the queue and the
//   snapshot, row-pass, multiply and output registers; then the sixteen words
//   show on rsp_word with rsp_strobe high, one word per cycle; run_last marks the
//   sixteenth. Streamed back to back, the block rate is set by the back end: a
//   snapshot state, a row-pass state and an emit state through the single serial
//   multiply/scale path; it takes the next block only once idle. Results cannot be
//   held off: each word is valid for exactly one cycle.
//   Level-scale registers sit on the csr_ port (index 0..5, always ready);
//   write them only while the block is idle. Writes to other indexes are dropped.
//   Reset (synchronous) empties the queue and pipeline, clears the fill count and
//   restores the level-scale defaults; the store itself is not cleared.
module luma_dc_hadamard_dequant_top import ldhd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_word_type      req_word,
   output logic              rsp_strobe,
   output rsp_word_type      rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [LS_W-1:0]   csr_data
);

   scale_set_type   scale_ff, scale_in;
   job_push_type    job_push;
   job_type         q_job;
   logic            q_valid;
   logic            pop;
   coeff_block_type store;

   assign csr_ready = 1'b1;

   // level-scale register file: one word per qp mod 6
   always_comb begin
      scale_in = scale_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEVEL_SCALE_M0: scale_in[0] = csr_data;
            CSR_LEVEL_SCALE_M1: scale_in[1] = csr_data;
            CSR_LEVEL_SCALE_M2: scale_in[2] = csr_data;
            CSR_LEVEL_SCALE_M3: scale_in[3] = csr_data;
            CSR_LEVEL_SCALE_M4: scale_in[4] = csr_data;
            CSR_LEVEL_SCALE_M5: scale_in[5] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   // front: store fill and job classification
   ldhd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .job_taken (pop),
      .job_push  (job_push),
      .store     (store)
   );

   // decouple front and back
   ldhd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .job_push (job_push),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_job    (q_job)
   );

   // back: transform, scale, emit
   ldhd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .pop        (pop),
      .store      (store),
      .scale      (scale_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

FILE: design/ldhd_checker.sv
// Port-level checker for the luma DC inverse Hadamard block, bound to the top.
module ldhd_checker import ldhd_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_word,
   input logic         rsp_strobe,
   input rsp_word_type rsp_word
);

   // reset leaves no result and no stall behind
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("output strobe or busy set after reset");

   // a taken block end stalls the front until the snapshot is made
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.block_end) |=> busy)
      else $error("busy did not rise after a block end");

   // the sixteen results of a block come back to back
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.run_last) |=> rsp_strobe)
      else $error("gap inside a result burst");

   // a new burst never follows the last word directly
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.run_last) |=> !rsp_strobe)
      else $error("result right after the last word of a block");

   // results only after a block end has been seen within the pipeline depth
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_strobe) && !$past(reset, 4) && !$past(reset, 3))
         |-> $past(busy, 4))
      else $error("burst started without a preceding block snapshot");

endmodule

bind luma_dc_hadamard_dequant_top ldhd_checker u_ldhd_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

FILE: test/luma_dc_hadamard_dequant_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the luma DC inverse Hadamard and dequantization block.
module luma_dc_hadamard_dequant_top_test;
   import ldhd_pkg::*;

   // Track the coefficient store and scale registers, and queue the expected results.
   class dc_scoreboard;
      longint coeff_mem [N_COEFF];
      int unsigned slot;
      level_scale_type scale [N_SCALE];
      int sgn [4][4];
      rsp_word_type dc_expected_q [$];
      int unsigned mismatches;

      function new();
         slot = 0;
         mismatches = 0;
         foreach (coeff_mem[i]) coeff_mem[i] = 0;
         foreach (scale[i]) scale[i] = SCALE_RESET[i];
         sgn = '{'{1, 1, 1, 1}, '{1, 1, -1, -1}, '{1, -1, -1, 1}, '{1, -1, 1, -1}};
      endfunction

      function int unsigned pending();
         return dc_expected_q.size();
      endfunction

      function void note_scale(logic [CSR_IW-1:0] index, level_scale_type value);
         if (index < N_SCALE) scale[index] = value;
      endfunction

      // Store one accepted word; on block end, predict all sixteen results.
      function void note_word(req_word_type w);
         longint col_sum [4][4];
         longint tf, prod, val;
         int unsigned qdiv, qmod;
         rsp_word_type r;
         coeff_mem[slot] = longint'($signed(w.coeff_in));
         slot = (slot + 1) % N_COEFF;
         if (!w.block_end) return;
         slot = 0;
         qdiv = w.quant_param / 6;
         qmod = w.quant_param % 6;
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
               col_sum[i][j] = 0;
               for (int k = 0; k < 4; k++)
                  col_sum[i][j] += sgn[i][k] * coeff_mem[k * 4 + j];
            end
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
               tf = 0;
               for (int k = 0; k < 4; k++) tf += col_sum[i][k] * sgn[k][j];
               prod = tf * longint'(scale[qmod]);
               if (qdiv >= 6)
                  val = prod <<< (qdiv - 6);
               else
                  val = (prod + (longint'(1) << (5 - qdiv))) >>> (6 - qdiv);
               if (val > OUT_MAX) val = OUT_MAX;
               if (val < OUT_MIN) val = OUT_MIN;
               r.dc_value = val[OUT_W-1:0];
               r.run_last = (i == 3 && j == 3);
               dc_expected_q.push_back(r);
            end
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (dc_expected_q.size() == 0) begin
            $error("unexpected result word: dc_value %0d run_last %0b",
                   got.dc_value, got.run_last);
            mismatches++;
            return;
         end
         want = dc_expected_q.pop_front();
         if (got.dc_value !== want.dc_value) begin
            $error("dc_value: expected %0d, actual %0d", want.dc_value, got.dc_value);
            mismatches++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
            mismatches++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT   = 200000;
   // results pass the pipeline and come as a sixteen-word burst; settle well past that
   localparam int SETTLE_CYCLES = 24;

   localparam logic [CSR_IW-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam logic [CSR_IW-1:0] SCALE_REG [N_SCALE] = '{
      CSR_LEVEL_SCALE_M0, CSR_LEVEL_SCALE_M1, CSR_LEVEL_SCALE_M2,
      CSR_LEVEL_SCALE_M3, CSR_LEVEL_SCALE_M4, CSR_LEVEL_SCALE_M5};

   // opening block: field extremes and mixed signs in raster order
   localparam int OPENING_COEFFS [N_COEFF] = '{
      32767, -32768, 0, -1, 1, 12345, -12345, 255,
      -256, 4096, -4096, 7, -7, 32767, -32768, 100};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   req_word_type      req_word = '0;
   logic              rsp_strobe;
   rsp_word_type      rsp_word;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [LS_W-1:0]   csr_data = '0;

   dc_scoreboard board;
   int unsigned  sender_idle_pct = 0;
   int unsigned  cycle_count = 0;

   always #5 clock = ~clock;

   luma_dc_hadamard_dequant_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Take every strobed result word; the receiver never stalls.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_word(rsp_word);
   end

   // Present one word, idling first at the current rate, and hold it until busy is low
   // at an edge. Leave start high so a following word streams without a gap.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_word(w);
   endtask

   // Sixteen equal coefficients: drives the DC term to its extreme.
   task automatic send_flat_block(input int coeff, input int unsigned qp);
      req_word_type w;
      for (int k = 0; k < N_COEFF; k++) begin
         w.coeff_in    = coeff_type'(coeff);
         w.quant_param = 6'((k == N_COEFF - 1) ? qp : $urandom_range(63));
         w.block_end   = (k == N_COEFF - 1);
         send_word(w);
      end
   endtask

   // Mostly full blocks; the rest end early or run past sixteen and wrap the store.
   task automatic send_random_blocks(input int unsigned word_budget);
      int unsigned sent, len, pick, flavor;
      logic        neg;
      req_word_type w;
      sent = 0;
      while (sent < word_budget) begin
         pick = $urandom_range(99);
         if (pick < 70)      len = N_COEFF;
         else if (pick < 85) len = $urandom_range(N_COEFF - 1, 1);
         else                len = $urandom_range(24, N_COEFF + 1);
         flavor = $urandom_range(3);
         neg    = 1'($urandom_range(1));
         for (int unsigned k = 1; k <= len; k++) begin
            unique case (flavor)
               2: begin
                  w.coeff_in = coeff_type'(int'($urandom_range(127)) - 64);
               end
               3: begin
                  w.coeff_in = neg ? coeff_type'(-32768) : coeff_type'(32767);
               end
               default: begin
                  w.coeff_in = coeff_type'($urandom);
               end
            endcase
            w.block_end = (k == len);
            if (w.block_end && $urandom_range(9) != 0)
               w.quant_param = 6'($urandom_range(51));
            else
               w.quant_param = 6'($urandom_range(63));
            send_word(w);
         end
         sent += len;
      end
   endtask

   // Hold the sender off until every expected word has come back, then let the block settle.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IW-1:0] index, input level_scale_type value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.note_scale(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Load all six scale words, then poke the unmapped indexes, which must be dropped.
   task automatic write_scales(input scale_set_type set);
      for (int i = 0; i < N_SCALE; i++) csr_write(SCALE_REG[i], set[i]);
      csr_write(CSR_UNMAPPED_LO, level_scale_type'($urandom));
      csr_write(CSR_UNMAPPED_HI, level_scale_type'($urandom));
   endtask

   initial begin
      req_word_type  w;
      scale_set_type scales;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on the reset scale words. The first block fills every store slot,
      // so later early block ends never read an unwritten entry.
      sender_idle_pct = 16;
      for (int k = 0; k < N_COEFF; k++) begin
         w.coeff_in    = coeff_type'(OPENING_COEFFS[k]);
         w.quant_param = (k == N_COEFF - 1) ? 6'd0 : 6'($urandom_range(63));
         w.block_end   = (k == N_COEFF - 1);
         send_word(w);
      end
      // Early block ends: one new coefficient each, the rest of the store kept.
      // qp 51 is the top of the normal range, 63 lies above it (left shift by four),
      // 36 is the first qp with a left shift, 35 the last with rounding.
      w = '{coeff_in: 16'sd500, quant_param: 6'd51, block_end: 1'b1};
      send_word(w);
      w = '{coeff_in: -16'sd500, quant_param: 6'd63, block_end: 1'b1};
      send_word(w);
      w = '{coeff_in: 16'sd1, quant_param: 6'd36, block_end: 1'b1};
      send_word(w);
      w = '{coeff_in: -16'sd1, quant_param: 6'd35, block_end: 1'b1};
      send_word(w);
      drain_results();

      // Phase one: random scale words, light sender idling.
      foreach (scales[i]) scales[i] = level_scale_type'($urandom_range(8191));
      write_scales(scales);
      send_random_blocks(45);
      drain_results();

      // Phase two: maximum scale words, heavy sender idling; saturate both rails first.
      sender_idle_pct = 67;
      scales = '1;
      write_scales(scales);
      send_flat_block(32767, 60);
      send_flat_block(-32768, 63);
      send_random_blocks(45);
      drain_results();

      // Phase three: mixed extremes, sender streams back to back.
      sender_idle_pct = 0;
      scales[0] = '0;
      scales[1] = '1;
      scales[2] = 13'd1;
      scales[3] = 13'd4096;
      scales[4] = level_scale_type'($urandom_range(8191));
      scales[5] = level_scale_type'($urandom_range(8191));
      write_scales(scales);
      send_random_blocks(45);
      drain_results();

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: luma_dc_hadamard_dequant_top.f
design/ldhd_pkg.sv
design/ldhd_front.sv
design/ldhd_queue.sv
design/ldhd_back.sv
design/luma_dc_hadamard_dequant_top.sv
design/ldhd_checker.sv
test/luma_dc_hadamard_dequant_top_test.sv
